// ===== design/sbsu_pkg.sv =====
// ----------------------------------------------------------------------------
// sbsu_pkg
// Shared types and constants for the byte-stuffed bit stream unpacker.
// ----------------------------------------------------------------------------
package sbsu_pkg;

  localparam logic [7:0] DELIM_BYTE = 8'h40;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [3:0] BYTE_BITS  = 4'd8;
  localparam logic [7:0] DIGIT_MAX  = DIGIT_ZERO + {4'd0, BYTE_BITS};

  typedef enum logic [1:0] {
    ST_BIT   = 2'd0,
    ST_END   = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_NORMAL = 4'b0001,
    PH_ESCAPE = 4'b0010,
    PH_COUNT  = 4'b0100,
    PH_HALT   = 4'b1000
  } phase_t;

  typedef logic [3:0] count_t;
  typedef logic [2:0] bit_idx_t;

endpackage

// ===== design/stuffed_bit_stream_unpacker.sv =====
// ----------------------------------------------------------------------------
// stuffed_bit_stream_unpacker
// Decodes a byte-stuffed framed stream into single data bits, MSB first.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one framed byte per word, or
// stream_end to signal the source is dry. Output channel (out_valid/
// out_ready) carries one decoded bit per word with run_last on the final
// word caused by an input word and status (bit, end, framing error).
// An accepted byte is decoded in the cycle it is taken and its run of up
// to eight output words sits in a holding register; from there it moves
// into the output shifter, and words then leave one per cycle while the
// receiver is ready. A full data byte therefore yields eight output words,
// a partial byte n words and an end or error status a single word; escape
// and count bytes produce no word. Input is taken again while the shifter
// still drains, limited by the single holding register.
// After end or error the block halts and answers each further word with
// the same status until reset. Reset is synchronous and empties both
// stages and returns the parser to normal phase. When the receiver
// stalls, the output word holds and input is taken until the holding
// register is full.
// ----------------------------------------------------------------------------
module stuffed_bit_stream_unpacker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       stream_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_bit,
  output logic       run_last,
  output logic [1:0] status
);

  sbsu_pkg::phase_t   phase, phase_next;
  sbsu_pkg::count_t   count, count_next;

  logic               dec_emit;
  logic [7:0]         dec_data;
  sbsu_pkg::bit_idx_t dec_idx;
  sbsu_pkg::status_t  dec_status;

  logic               pend_valid;
  logic [7:0]         pend_data;
  sbsu_pkg::bit_idx_t pend_idx;
  sbsu_pkg::status_t  pend_status;

  logic               sh_valid;
  logic [7:0]         sh_data;
  sbsu_pkg::bit_idx_t sh_idx;
  sbsu_pkg::status_t  sh_status;

  logic               in_fire, out_fire, sh_last, pend_load;
  sbsu_pkg::count_t   n_clamp, n_minus1;
  logic [7:0]         digit_diff;

  assign out_fire  = out_valid && out_ready;
  assign sh_last   = (sh_idx == '0);
  assign pend_load = pend_valid && (!sh_valid || (out_fire && sh_last));
  assign in_ready  = !pend_valid || pend_load;
  assign in_fire   = in_valid && in_ready;

  assign n_clamp    = (count > sbsu_pkg::BYTE_BITS) ? sbsu_pkg::BYTE_BITS : count;
  assign n_minus1   = n_clamp - 4'd1;
  assign digit_diff = in_byte - sbsu_pkg::DIGIT_ZERO;

  // parser: next phase and the run an input word produces
  always_comb begin
    phase_next = phase;
    count_next = count;
    dec_emit   = 1'b0;
    dec_data   = in_byte;
    dec_idx    = 3'd7;
    dec_status = sbsu_pkg::ST_BIT;
    case (phase)
      sbsu_pkg::PH_NORMAL: begin
        if (stream_end) begin
          phase_next = sbsu_pkg::PH_HALT;
          count_next = {2'b00, sbsu_pkg::ST_END};
          dec_emit   = 1'b1;
          dec_data   = '0;
          dec_idx    = '0;
          dec_status = sbsu_pkg::ST_END;
        end else if (in_byte == sbsu_pkg::DELIM_BYTE) begin
          phase_next = sbsu_pkg::PH_ESCAPE;
        end else begin
          dec_emit = 1'b1;
        end
      end
      sbsu_pkg::PH_ESCAPE: begin
        if (stream_end || !((in_byte == sbsu_pkg::DELIM_BYTE) ||
            (in_byte >= sbsu_pkg::DIGIT_ZERO && in_byte <= sbsu_pkg::DIGIT_MAX))) begin
          phase_next = sbsu_pkg::PH_HALT;
          count_next = {2'b00, sbsu_pkg::ST_ERROR};
          dec_emit   = 1'b1;
          dec_data   = '0;
          dec_idx    = '0;
          dec_status = sbsu_pkg::ST_ERROR;
        end else if (in_byte == sbsu_pkg::DELIM_BYTE) begin
          phase_next = sbsu_pkg::PH_NORMAL;
          dec_emit   = 1'b1;
        end else if (in_byte == sbsu_pkg::DIGIT_ZERO) begin
          phase_next = sbsu_pkg::PH_HALT;
          count_next = {2'b00, sbsu_pkg::ST_END};
          dec_emit   = 1'b1;
          dec_data   = '0;
          dec_idx    = '0;
          dec_status = sbsu_pkg::ST_END;
        end else begin
          phase_next = sbsu_pkg::PH_COUNT;
          count_next = digit_diff[3:0];
        end
      end
      sbsu_pkg::PH_COUNT: begin
        if (stream_end) begin
          phase_next = sbsu_pkg::PH_HALT;
          count_next = {2'b00, sbsu_pkg::ST_ERROR};
          dec_emit   = 1'b1;
          dec_data   = '0;
          dec_idx    = '0;
          dec_status = sbsu_pkg::ST_ERROR;
        end else begin
          phase_next = sbsu_pkg::PH_NORMAL;
          count_next = '0;
          dec_emit   = (n_clamp != '0);
          dec_idx    = n_minus1[2:0];
        end
      end
      sbsu_pkg::PH_HALT: begin
        dec_emit   = 1'b1;
        dec_data   = '0;
        dec_idx    = '0;
        dec_status = (count == {2'b00, sbsu_pkg::ST_END}) ? sbsu_pkg::ST_END
                                                          : sbsu_pkg::ST_ERROR;
      end
      default: begin
        phase_next = sbsu_pkg::PH_NORMAL;
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sbsu_pkg::PH_NORMAL;
      count <= '0;
    end else if (in_fire) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  // holding register for one decoded run
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_fire && dec_emit) begin
      pend_valid <= 1'b1;
    end else if (pend_load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && dec_emit) begin
      pend_data   <= dec_data;
      pend_idx    <= dec_idx;
      pend_status <= dec_status;
    end
  end

  // output shifter, one word per cycle while the receiver is ready
  always_ff @(posedge clk) begin
    if (rst) begin
      sh_valid <= 1'b0;
    end else if (pend_load) begin
      sh_valid <= 1'b1;
    end else if (out_fire && sh_last) begin
      sh_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      sh_data   <= pend_data;
      sh_idx    <= pend_idx;
      sh_status <= pend_status;
    end else if (out_fire && !sh_last) begin
      sh_idx <= sh_idx - 3'd1;
    end
  end

  assign out_valid = sh_valid;
  assign out_bit   = sh_data[sh_idx];
  assign run_last  = sh_last;
  assign status    = sh_status;

`ifndef SYNTH
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != sbsu_pkg::ST_BIT) |-> (run_last && !out_bit))
    else $error("status word not a single run_last word");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == sbsu_pkg::PH_HALT) |=> (phase == sbsu_pkg::PH_HALT))
    else $error("parser left halt without reset");

  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (pend_valid && sh_valid))
    else $error("input stalled with room available");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");
`endif

endmodule
